// ----- rtl/bbd_pkg.sv -----
// Shared types, constants and pixel math for the bilinear Bayer demosaic.
// Used by bbd_line_store and bayer_bilinear_demosaic_top; no dependencies.
`default_nettype none

package bbd_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_BITS   = 12;
  localparam int DIM_BITS   = 13;
  localparam int PIX_BITS   = 16;

  typedef logic [PIX_BITS-1:0] pix_t;
  typedef logic [COL_BITS-1:0] col_t;
  typedef logic [DIM_BITS-1:0] dim_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_PATTERN   = 3'd0;
  localparam logic [2:0] CFG_WIDTH     = 3'd1;
  localparam logic [2:0] CFG_HEIGHT    = 3'd2;
  localparam logic [2:0] CFG_COL_SHIFT = 3'd3;
  localparam logic [2:0] CFG_ROW_SHIFT = 3'd4;

  // Color site codes, {column bit, row bit}
  localparam logic [1:0] SITE_RED   = 2'b00;
  localparam logic [1:0] SITE_GR_R  = 2'b10;
  localparam logic [1:0] SITE_GR_B  = 2'b01;
  localparam logic [1:0] SITE_BLUE  = 2'b11;

  // One output pixel
  typedef struct packed {
    pix_t red;
    pix_t green;
    pix_t blue;
    col_t col;
    col_t row;
    logic frame_done;
  } rgb_px_t;

  // Line store read request and write port
  typedef struct packed {
    logic en;
    col_t col;
  } ls_rd_t;

  typedef struct packed {
    logic we;
    col_t col;
    pix_t data;
  } ls_wr_t;

  // Zero acts as one, anything above the maximum acts as the maximum
  function automatic dim_t clamp_dim(input dim_t v, input dim_t maxv);
    dim_t res;
    if (v == '0) begin
      res = dim_t'(1);
    end else if (v > maxv) begin
      res = maxv;
    end else begin
      res = v;
    end
    return res;
  endfunction

  // Floored mean of two pixels
  function automatic pix_t avg2(input pix_t a, input pix_t b);
    logic [PIX_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[PIX_BITS:1];
  endfunction

  // Build one RGB pixel from its center and neighbor pairs
  function automatic rgb_px_t make_px(input col_t x, input col_t y,
                                      input dim_t w, input dim_t h,
                                      input logic [1:0] pattern,
                                      input logic cshift, input logic rshift,
                                      input pix_t ctr, input pix_t hl,
                                      input pix_t hr, input pix_t vu,
                                      input pix_t vd);
    rgb_px_t px;
    logic    cb;
    logic    rb;
    dim_t    xp1;
    dim_t    yp1;
    pix_t    hz;
    pix_t    vt;
    cb  = pattern[1] ^ x[0] ^ cshift;
    rb  = pattern[0] ^ y[0] ^ rshift;
    xp1 = {1'b0, x} + dim_t'(1);
    yp1 = {1'b0, y} + dim_t'(1);
    hz  = ((x != '0) && (xp1 < w)) ? avg2(hl, hr) : ctr;
    vt  = ((y != '0) && (yp1 < h)) ? avg2(vu, vd) : ctr;
    case ({cb, rb})
      SITE_RED: begin
        px.red = ctr; px.green = hz;  px.blue = vt;
      end
      SITE_GR_R: begin
        px.red = hz;  px.green = ctr; px.blue = vt;
      end
      SITE_GR_B: begin
        px.red = vt;  px.green = ctr; px.blue = hz;
      end
      default: begin
        px.red = vt;  px.green = hz;  px.blue = ctr;
      end
    endcase
    px.col        = x;
    px.row        = y;
    px.frame_done = (xp1 >= w) && (yp1 >= h);
    return px;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/bayer_bilinear_demosaic_top.sv -----
// Top level of the streaming bilinear Bayer demosaic.
// Depends on bbd_pkg and bbd_line_store.
//
// Raw Bayer pixels enter on in_* in raster order, one item per clock while
// in_tready is high; RGB pixels leave on out_* one row late: the pixel at
// (c, r-1) is produced by the input at (c, r). The last row of a frame is
// flushed as it arrives, so an input there gives up to three results. out_tlast
// marks the final result of an input, out_tuser marks the frame's final pixel.
// An accepted input loads the read stage as the line stores are read; the
// result register is loaded from the read stage when it moves on.
// Throughput: one item per cycle while the receiver keeps up. On the last row
// the output port drains at most one result per cycle, so an input that makes
// two or three results stalls the input while they drain.
// Reset clears the row and column counters, the left-neighbor registers and the
// pipeline; line store contents stay unknown, and are read before being written.
// When the receiver stalls, the result register holds, the read stage holds
// behind it, and in_tready drops until a slot frees. Configuration is written
// by the user through cfg_we/cfg_addr/cfg_wdata only while idle; not enforced.
`default_nettype none

module bayer_bilinear_demosaic_top
  import bbd_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  // configuration
  input  wire         cfg_we,
  input  wire  [2:0]  cfg_addr,
  input  wire  [12:0] cfg_wdata,
  // raw pixel stream
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,   // [15:0] raw_pixel
  // RGB pixel stream
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [71:0] out_tdata,  // [15:0] red, [31:16] green, [47:32] blue,
                                  // [59:48] out_column, [71:60] out_row
  output logic        out_tlast,  // last_of_run
  output logic [0:0]  out_tuser   // [0] frame_done
);

  // Configuration registers
  logic [1:0] cfg_pattern_r;
  dim_t       cfg_width_r;
  dim_t       cfg_height_r;
  logic       cfg_col_shift_r;
  logic       cfg_row_shift_r;

  // Position and neighbor state
  col_t col_r, col_nxt;
  col_t row_r, row_nxt;
  pix_t prev_a_r;
  pix_t prev_b_r;
  pix_t mid_hist_r;

  // Read stage
  logic s1_valid_r;
  col_t s1_col_r;
  col_t s1_row_r;
  pix_t s1_raw_r;
  pix_t s1_pa_r;
  pix_t s1_pb_r;
  logic s1_fwd_r;

  // Result register
  rgb_px_t    s2_px_r [3];
  logic [2:0] s2_mask_r;

  logic       in_fire;
  logic       out_fire;
  logic       s1_adv;
  logic       s2_free;
  dim_t       w_eff;
  dim_t       h_eff;
  logic       in_row_end;
  logic       in_last_row;
  logic       s1_row_end;
  logic       s1_last_row;
  pix_t       up_rd;
  pix_t       mid_rd;
  pix_t       right_rd;
  pix_t       up_val;
  rgb_px_t    px_up;
  rgb_px_t    px_left;
  rgb_px_t    px_here;
  logic [2:0] s1_mask;
  logic [2:0] sel_bit;
  logic [1:0] sel_idx;
  rgb_px_t    out_px;
  ls_rd_t     ls_rd;
  ls_wr_t     newer_wr;
  ls_wr_t     older_wr;

  // Configuration write decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_pattern_r   <= 2'd0;
      cfg_width_r     <= dim_t'(MAX_WIDTH);
      cfg_height_r    <= dim_t'(MAX_HEIGHT);
      cfg_col_shift_r <= 1'b0;
      cfg_row_shift_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_PATTERN:   cfg_pattern_r   <= cfg_wdata[1:0];
        CFG_WIDTH:     cfg_width_r     <= cfg_wdata;
        CFG_HEIGHT:    cfg_height_r    <= cfg_wdata;
        CFG_COL_SHIFT: cfg_col_shift_r <= cfg_wdata[0];
        CFG_ROW_SHIFT: cfg_row_shift_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign w_eff = clamp_dim(cfg_width_r, dim_t'(MAX_WIDTH));
  assign h_eff = clamp_dim(cfg_height_r, dim_t'(MAX_HEIGHT));

  // Handshake
  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign s2_free  = (s2_mask_r == 3'b000) ||
                    (out_fire && ((s2_mask_r & (s2_mask_r - 3'd1)) == 3'b000));
  assign s1_adv    = s1_valid_r && s2_free;
  assign in_tready = !s1_valid_r || s2_free;

  // Raster position
  assign in_row_end  = ({1'b0, col_r} + dim_t'(1)) >= w_eff;
  assign in_last_row = ({1'b0, row_r} + dim_t'(1)) >= h_eff;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_fire) begin
      if (in_row_end) begin
        col_nxt = '0;
        row_nxt = in_last_row ? '0 : row_r + col_t'(1);
      end else begin
        col_nxt = col_r + col_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      prev_a_r <= '0;
      prev_b_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (in_fire) begin
        prev_a_r <= in_tdata;
        prev_b_r <= prev_a_r;
      end
    end
  end

  // Line stores: read at accept, newer row written at accept, older row
  // written with the resolved middle pixel when the read stage moves on
  assign ls_rd.en      = in_fire;
  assign ls_rd.col     = col_r;
  assign newer_wr.we   = in_fire;
  assign newer_wr.col  = col_r;
  assign newer_wr.data = in_tdata;
  assign older_wr.we   = s1_adv;
  assign older_wr.col  = s1_col_r;
  assign older_wr.data = mid_rd;

  bbd_line_store u_line_store (
    .clk      (clk),
    .rd_req   (ls_rd),
    .newer_wr (newer_wr),
    .older_wr (older_wr),
    .up_rd    (up_rd),
    .mid_rd   (mid_rd),
    .right_rd (right_rd)
  );

  // Read stage registers; forward when the older-row write of the item
  // ahead lands in the same cycle as this item's read of that column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_col_r <= col_r;
      s1_row_r <= row_r;
      s1_raw_r <= in_tdata;
      s1_pa_r  <= prev_a_r;
      s1_pb_r  <= prev_b_r;
      s1_fwd_r <= s1_valid_r && (s1_col_r == col_r);
    end
    if (s1_adv) begin
      mid_hist_r <= mid_rd;
    end
  end

  // Result generation
  assign up_val      = s1_fwd_r ? mid_hist_r : up_rd;
  assign s1_row_end  = ({1'b0, s1_col_r} + dim_t'(1)) >= w_eff;
  assign s1_last_row = ({1'b0, s1_row_r} + dim_t'(1)) >= h_eff;

  always_comb begin
    // Row above, finished by this pixel
    px_up   = make_px(s1_col_r, s1_row_r - col_t'(1), w_eff, h_eff, cfg_pattern_r,
                      cfg_col_shift_r, cfg_row_shift_r,
                      mid_rd, mid_hist_r, right_rd, up_val, s1_raw_r);
    // Last row flush: the pixel to the left
    px_left = make_px(s1_col_r - col_t'(1), s1_row_r, w_eff, h_eff, cfg_pattern_r,
                      cfg_col_shift_r, cfg_row_shift_r,
                      s1_pa_r, s1_pb_r, s1_raw_r, s1_pa_r, s1_pa_r);
    // Last row flush: this pixel at the row end
    px_here = make_px(s1_col_r, s1_row_r, w_eff, h_eff, cfg_pattern_r,
                      cfg_col_shift_r, cfg_row_shift_r,
                      s1_raw_r, s1_pa_r, s1_raw_r, s1_raw_r, s1_raw_r);
    s1_mask = {s1_last_row && s1_row_end,
               s1_last_row && (s1_col_r != '0),
               s1_row_r != '0};
  end

  // Result register, drained lowest slot first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_mask_r <= 3'b000;
    end else if (s1_adv) begin
      s2_mask_r <= s1_mask;
    end else if (out_fire) begin
      s2_mask_r <= s2_mask_r & ~sel_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_px_r[0] <= px_up;
      s2_px_r[1] <= px_left;
      s2_px_r[2] <= px_here;
    end
  end

  // Output select
  always_comb begin
    if (s2_mask_r[0]) begin
      sel_idx = 2'd0;
      sel_bit = 3'b001;
    end else if (s2_mask_r[1]) begin
      sel_idx = 2'd1;
      sel_bit = 3'b010;
    end else begin
      sel_idx = 2'd2;
      sel_bit = 3'b100;
    end
    out_px = s2_px_r[sel_idx];
  end

  assign out_tvalid   = (s2_mask_r != 3'b000);
  assign out_tdata    = {out_px.row, out_px.col, out_px.blue, out_px.green, out_px.red};
  assign out_tlast    = ((s2_mask_r & (s2_mask_r - 3'd1)) == 3'b000);
  assign out_tuser[0] = out_px.frame_done;

`ifndef ASSERT_OFF
  // A stalled read stage keeps its item
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_free |=> s1_valid_r && $stable(s1_col_r) && $stable(s1_raw_r))
    else $error("read stage lost its item while stalled");

  // Pending results are kept while the receiver stalls
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_mask_r != 3'b000) && !out_tready |=> $stable(s2_mask_r))
    else $error("pending results changed during an output stall");

  // Reset empties the pipeline
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !s1_valid_r && (s2_mask_r == 3'b000))
    else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

// ----- rtl/bbd_line_store.sv -----
// Two line stores (older and newer row) of the demosaic, with registered read outputs.
// Depends on bbd_pkg for the request and write port types.
`default_nettype none

module bbd_line_store
  import bbd_pkg::*;
(
  input  wire    clk,
  input  ls_rd_t rd_req,
  input  ls_wr_t newer_wr,
  input  ls_wr_t older_wr,
  output pix_t   up_rd,
  output pix_t   mid_rd,
  output pix_t   right_rd
);

  pix_t older_mem_r [MAX_WIDTH];
  pix_t newer_mem_r [MAX_WIDTH];
  pix_t up_rd_r;
  pix_t mid_rd_r;
  pix_t right_rd_r;
  col_t right_col;

  // Right neighbor column; wraps at the top, value then unused
  assign right_col = rd_req.col + col_t'(1);

  // Older row: read column c, written back with the row below it
  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      up_rd_r <= older_mem_r[rd_req.col];
    end
    if (older_wr.we) begin
      older_mem_r[older_wr.col] <= older_wr.data;
    end
  end

  // Newer row: read columns c and c+1, read-first against the write
  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      mid_rd_r   <= newer_mem_r[rd_req.col];
      right_rd_r <= newer_mem_r[right_col];
    end
    if (newer_wr.we) begin
      newer_mem_r[newer_wr.col] <= newer_wr.data;
    end
  end

  assign up_rd    = up_rd_r;
  assign mid_rd   = mid_rd_r;
  assign right_rd = right_rd_r;

endmodule

`default_nettype wire
